[hw/rtl/orq_pkg.sv]
// Shared types, constants and the control store for the overwriting ring queue.
// Used by the sequencer and the top level; depends on nothing else.
package orq_pkg;

	localparam int DEPTH_DEF = 5;
	localparam int TAG_W = 16;
	localparam int YEAR_W = 15;
	localparam int OCC_W = 3;

	localparam int OP_W = 4;
	localparam int COND_W = 3;
	localparam int UPC_W = 4;

	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_ACCEPT = 4'd1;
	localparam logic [OP_W-1:0] OP_PUSH = 4'd2;
	localparam logic [OP_W-1:0] OP_SUM = 4'd3;
	localparam logic [OP_W-1:0] OP_DIVI = 4'd4;
	localparam logic [OP_W-1:0] OP_DIV = 4'd5;
	localparam logic [OP_W-1:0] OP_AVG = 4'd6;
	localparam logic [OP_W-1:0] OP_POP = 4'd7;
	localparam logic [OP_W-1:0] OP_POPOUT = 4'd8;

	localparam logic [COND_W-1:0] C_NEXT = 3'd0;
	localparam logic [COND_W-1:0] C_ACCEPT = 3'd1;
	localparam logic [COND_W-1:0] C_LOOP = 3'd2;
	localparam logic [COND_W-1:0] C_OUT = 3'd3;

	localparam logic [UPC_W-1:0] A_IDLE = 4'd0;
	localparam logic [UPC_W-1:0] A_PUSH = 4'd1;
	localparam logic [UPC_W-1:0] A_SUM = 4'd2;
	localparam logic [UPC_W-1:0] A_DRAIN = 4'd3;
	localparam logic [UPC_W-1:0] A_DIVI = 4'd4;
	localparam logic [UPC_W-1:0] A_DIV = 4'd5;
	localparam logic [UPC_W-1:0] A_AVG = 4'd6;
	localparam logic [UPC_W-1:0] A_POP = 4'd7;
	localparam logic [UPC_W-1:0] A_POPOUT = 4'd8;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [COND_W-1:0] cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic act;
		logic k_last;
		logic out_busy;
	} stat_t;

	function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] a);
		ctrl_t w;
		w = '{op: OP_NONE, cond: C_NEXT, target: A_IDLE};
		case (a)
			A_IDLE: w = '{op: OP_ACCEPT, cond: C_ACCEPT, target: A_POP};
			A_PUSH: w = '{op: OP_PUSH, cond: C_NEXT, target: A_IDLE};
			A_SUM: w = '{op: OP_SUM, cond: C_LOOP, target: A_SUM};
			A_DRAIN: w = '{op: OP_NONE, cond: C_NEXT, target: A_IDLE};
			A_DIVI: w = '{op: OP_DIVI, cond: C_NEXT, target: A_IDLE};
			A_DIV: w = '{op: OP_DIV, cond: C_LOOP, target: A_DIV};
			A_AVG: w = '{op: OP_AVG, cond: C_OUT, target: A_IDLE};
			A_POP: w = '{op: OP_POP, cond: C_NEXT, target: A_IDLE};
			A_POPOUT: w = '{op: OP_POPOUT, cond: C_OUT, target: A_IDLE};
			default: w = '{op: OP_NONE, cond: C_OUT, target: A_IDLE};
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/orq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module orq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hw/rtl/orq_useq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on orq_pkg.
module orq_useq (
	input logic clk,
	input logic arst_n,
	input orq_pkg::stat_t stat,
	output orq_pkg::ctrl_t cw,
	output logic in_ready
);
	import orq_pkg::*;

	logic [UPC_W-1:0] upc_q;
	logic [UPC_W-1:0] upc_d;
	logic hs;

	assign cw = ucode_rom(upc_q);
	assign in_ready = (cw.cond == C_ACCEPT);
	assign hs = stat.in_valid && in_ready;

	always_comb begin
		case (cw.cond)
			C_NEXT: upc_d = upc_q + 1'b1;
			C_ACCEPT: begin
				if (!hs) begin
					upc_d = upc_q;
				end else if (stat.act) begin
					upc_d = cw.target;
				end else begin
					upc_d = upc_q + 1'b1;
				end
			end
			C_LOOP: upc_d = stat.k_last ? upc_q + 1'b1 : cw.target;
			C_OUT: upc_d = stat.out_busy ? upc_q : cw.target;
			default: upc_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= A_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end
endmodule

[hw/rtl/overwriting_ring_queue_with_average_top.sv]
// Top level of the overwriting ring queue with a running year average.
// Depends on orq_pkg, orq_ram and orq_useq.
//
// Usage: one input beat carries an action (push or pop) with an entry tag and
// a signed year; each input beat yields exactly one output beat.
// A push onto a full queue drops the oldest entry, stores the new one and
// returns the average of all held years, truncated toward zero.
// A pop returns the oldest entry, or removed_valid low when the queue is empty.
// Every output beat carries the occupancy after the access.
// A pop reads the oldest entry and loads the output register. A push sums
// the n held years, n being the occupancy after the push, and divides by n
// over SW = 15 + clog2(DEPTH) quotient bits, the sum width (18 at DEPTH 5).
// The sum loop reads one year per cycle from the RAM port and the divider
// retires one quotient bit per cycle. One item is in flight at a time; the
// next input beat is taken in the cycle after the result is loaded.
// Reset clears the pointers, the count and the output valid flag; the queue is
// empty. A stalled receiver holds the output register; the next input beat is
// still accepted and processed, and its result waits until the register frees.
module overwriting_ring_queue_with_average_top #(
	parameter int DEPTH = orq_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic action,
	input logic [orq_pkg::TAG_W-1:0] entry_tag,
	input logic signed [orq_pkg::YEAR_W-1:0] year_value,
	output logic out_valid,
	input logic out_ready,
	output logic average_valid,
	output logic signed [orq_pkg::YEAR_W-1:0] average_year,
	output logic removed_valid,
	output logic [orq_pkg::TAG_W-1:0] removed_tag,
	output logic signed [orq_pkg::YEAR_W-1:0] removed_year,
	output logic [orq_pkg::OCC_W-1:0] occupancy
);
	import orq_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = YEAR_W + $clog2(DEPTH);
	localparam int LOOPMAX = (DEPTH > SW) ? DEPTH : SW;
	localparam int KW = $clog2(LOOPMAX + 1);
	localparam int RW = TAG_W + YEAR_W;

	ctrl_t cw;
	stat_t stat;

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic out_valid_q;
	logic pend_q;

	logic [IW-1:0] idx_q;
	logic [KW-1:0] k_q;
	logic signed [SW-1:0] sum_q;
	logic [SW-1:0] quo_q;
	logic [CW:0] rem_q;
	logic neg_q;
	logic hit_q;
	logic [TAG_W-1:0] tag_q;
	logic signed [YEAR_W-1:0] year_q;

	logic avg_valid_q;
	logic signed [YEAR_W-1:0] avg_year_q;
	logic rm_valid_q;
	logic [TAG_W-1:0] rm_tag_q;
	logic signed [YEAR_W-1:0] rm_year_q;
	logic [OCC_W-1:0] occ_q;

	logic hs;
	logic full;
	logic [IW-1:0] head_n;
	logic [CW-1:0] count_n;
	logic out_busy;
	logic load_out;
	logic ram_we;
	logic ram_re;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;
	logic signed [YEAR_W-1:0] rd_year;
	logic [SW-1:0] mag;
	logic [CW:0] shifted;
	logic [CW:0] diff;
	logic qbit;
	logic [SW-1:0] quo_sgn;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	orq_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cw(cw),
		.in_ready(in_ready)
	);

	orq_ram #(
		.WIDTH(RW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(tail_q),
		.wdata({tag_q, year_q}),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign hs = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;
	assign load_out = ((cw.op == OP_AVG) || (cw.op == OP_POPOUT)) && !out_busy;

	assign stat.in_valid = in_valid;
	assign stat.act = action;
	assign stat.k_last = (k_q == KW'(1));
	assign stat.out_busy = out_busy;

	assign full = (count_q == CW'(DEPTH));
	assign head_n = full ? nxt(head_q) : head_q;
	assign count_n = full ? count_q : count_q + 1'b1;

	assign ram_we = (cw.op == OP_PUSH);
	assign ram_re = (cw.op == OP_SUM) || ((cw.op == OP_POP) && (count_q != '0));
	assign ram_raddr = (cw.op == OP_SUM) ? idx_q : head_q;
	assign rd_year = ram_rdata[YEAR_W-1:0];

	assign mag = sum_q[SW-1] ? '0 - sum_q : sum_q;
	assign shifted = {rem_q[CW-1:0], quo_q[SW-1]};
	assign qbit = (shifted >= {1'b0, count_q});
	assign diff = shifted - {1'b0, count_q};
	assign quo_sgn = neg_q ? '0 - quo_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			pend_q <= (cw.op == OP_SUM);
			if (cw.op == OP_PUSH) begin
				head_q <= head_n;
				count_q <= count_n;
				tail_q <= nxt(tail_q);
			end
			if ((cw.op == OP_POP) && (count_q != '0)) begin
				head_q <= nxt(head_q);
				count_q <= count_q - 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cw.op == OP_ACCEPT) && hs) begin
			tag_q <= entry_tag;
			year_q <= year_value;
		end
		if (pend_q) begin
			sum_q <= sum_q + SW'(rd_year);
		end
		case (cw.op)
			OP_PUSH: begin
				idx_q <= head_n;
				k_q <= KW'(count_n);
				sum_q <= '0;
			end
			OP_SUM: begin
				idx_q <= nxt(idx_q);
				k_q <= k_q - 1'b1;
			end
			OP_DIVI: begin
				neg_q <= sum_q[SW-1];
				quo_q <= mag;
				rem_q <= '0;
				k_q <= KW'(SW);
			end
			OP_DIV: begin
				rem_q <= qbit ? diff : shifted;
				quo_q <= {quo_q[SW-2:0], qbit};
				k_q <= k_q - 1'b1;
			end
			OP_POP: begin
				hit_q <= (count_q != '0);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			occ_q <= OCC_W'(count_q);
			if (cw.op == OP_AVG) begin
				avg_valid_q <= 1'b1;
				avg_year_q <= quo_sgn[YEAR_W-1:0];
				rm_valid_q <= 1'b0;
				rm_tag_q <= '0;
				rm_year_q <= '0;
			end else begin
				avg_valid_q <= 1'b0;
				avg_year_q <= '0;
				rm_valid_q <= hit_q;
				rm_tag_q <= hit_q ? ram_rdata[RW-1:YEAR_W] : '0;
				rm_year_q <= hit_q ? rd_year : '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average_valid = avg_valid_q;
	assign average_year = avg_year_q;
	assign removed_valid = rm_valid_q;
	assign removed_tag = rm_tag_q;
	assign removed_year = rm_year_q;
	assign occupancy = occ_q;
endmodule

[hw/rtl/orq_chk.sv]
// Port-level checker for the overwriting ring queue, with its bind statement.
// Depends on orq_pkg and on the top level it is bound to.
module orq_chk #(
	parameter int DEPTH = orq_pkg::DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic average_valid,
	input logic signed [orq_pkg::YEAR_W-1:0] average_year,
	input logic removed_valid,
	input logic [orq_pkg::TAG_W-1:0] removed_tag,
	input logic signed [orq_pkg::YEAR_W-1:0] removed_year,
	input logic [orq_pkg::OCC_W-1:0] occupancy
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average_year)
			&& $stable(removed_tag) && $stable(removed_year) && $stable(occupancy))
		else $error("Output beat changed while stalled.");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && average_valid |-> !removed_valid)
		else $error("Push result also reports a removed entry.");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid && !removed_valid |-> occupancy == '0)
		else $error("Pop on an empty queue reports a nonzero occupancy.");

	a_push_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && average_valid |-> (DEPTH >= 8) || (occupancy != '0))
		else $error("Push result reports an empty queue.");

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DEPTH >= 8) || (occupancy <= DEPTH))
		else $error("Occupancy exceeds the queue depth.");
endmodule

bind overwriting_ring_queue_with_average_top orq_chk #(.DEPTH(DEPTH)) u_orq_chk (.*);
